// ----- rtl/core/stfsi_pkg.sv -----
`default_nettype none

package stfsi_pkg;

    localparam int KEY_W       = 32;
    localparam int DEPTH_DEF   = 64;
    localparam int OUTCOME_W   = 2;
    localparam int POSITION_W  = 6;
    localparam int COUNT_W     = 7;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CMP,
        OP_INS,
        OP_SWP
    } t_op;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_SWAPPED  = 2'd0,
        OC_LAST     = 2'd1,
        OC_INSERTED = 2'd2,
        OC_FULL     = 2'd3
    } t_outcome;

    typedef struct packed {
        t_op                     op;
        logic signed [KEY_W-1:0] key;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ----- rtl/core/sorted_table_find_swap_or_insert.sv -----
`default_nettype none

// Sorted table with find, swap-forward or insert. The table is a row of DEPTH
// cells, each holding one signed 32-bit entry; all cells compare their entry
// with the request key in the cycle the request is accepted and keep equal and
// greater flags. A binary-search step unit then probes those flags one midpoint
// per cycle, and the final step tells the row to swap an entry with its upper
// neighbor or to shift up and take the key in place, or leaves the row as it is
// on a hit at the last entry or a miss in a full table. A request passes through
// the accept cycle, one probe per midpoint (at most $clog2(DEPTH)+1 probes) and,
// on a miss, one more step to see the range empty. The result is valid in the
// following cycle, in which the next request can already be accepted; only one
// request is in flight, and the result register lets the next request in while
// a result waits, holding that search at its last step until the waiting result
// is taken. The table is empty after reset and needs no clearing pass.
module sorted_table_find_swap_or_insert #(
    parameter int DEPTH = stfsi_pkg::DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [stfsi_pkg::KEY_W-1:0]  i_key,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [stfsi_pkg::OUTCOME_W-1:0]          o_outcome,
    output logic [stfsi_pkg::POSITION_W-1:0]         o_position,
    output logic [stfsi_pkg::COUNT_W-1:0]            o_count
);
    import stfsi_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cell_cmd               c_cmd;
    logic [AW-1:0]           c_pos;
    logic [DEPTH-1:0]        c_eq;
    logic [DEPTH-1:0]        c_gt;
    logic signed [KEY_W-1:0] c_val [DEPTH];

    stfsi_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_key      (i_key),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_outcome  (o_outcome),
        .o_position (o_position),
        .o_count    (o_count),
        .i_eq       (c_eq),
        .i_gt       (c_gt),
        .o_cmd      (c_cmd),
        .o_pos      (c_pos)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [KEY_W-1:0] c_prev;
        logic signed [KEY_W-1:0] c_next;

        if (g == 0) begin : g_lo
            assign c_prev = '0;
        end else begin : g_mid_lo
            assign c_prev = c_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_hi
            assign c_next = '0;
        end else begin : g_mid_hi
            assign c_next = c_val[g+1];
        end

        stfsi_cell #(
            .IDX (g),
            .AW  (AW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (c_cmd),
            .i_pos  (c_pos),
            .i_prev (c_prev),
            .i_next (c_next),
            .o_val  (c_val[g]),
            .o_eq   (c_eq[g]),
            .o_gt   (c_gt[g])
        );
    end

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall
    ) else $error("request accepted but block not busy");

    a_result_from_search: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall)
    ) else $error("result appeared without a request in flight");

    a_full_position: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outcome == OC_FULL) |-> (o_position == '0)
    ) else $error("dropped insert reports nonzero position");

    a_cmd_only_when_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (c_cmd.op == OP_INS || c_cmd.op == OP_SWP) |=> (!o_stall && o_valid)
    ) else $error("table update without result");

endmodule

`default_nettype wire

// ----- rtl/core/stfsi_cell.sv -----
`default_nettype none

module stfsi_cell #(
    parameter int IDX = 0,
    parameter int AW  = 6
) (
    input  wire logic                           i_clk,
    input  wire stfsi_pkg::t_cell_cmd           i_cmd,
    input  wire logic [AW-1:0]                  i_pos,
    input  wire logic signed [stfsi_pkg::KEY_W-1:0] i_prev,
    input  wire logic signed [stfsi_pkg::KEY_W-1:0] i_next,
    output logic signed [stfsi_pkg::KEY_W-1:0]  o_val,
    output logic                                o_eq,
    output logic                                o_gt
);
    import stfsi_pkg::*;

    localparam logic [AW:0] MY_IDX = (AW+1)'(IDX);

    logic [AW:0]             c_pos;
    logic [AW:0]             c_pos_nx;
    logic signed [KEY_W-1:0] r_val;
    logic signed [KEY_W-1:0] n_val;
    logic                    r_eq;
    logic                    r_gt;

    assign c_pos    = {1'b0, i_pos};
    assign c_pos_nx = c_pos + (AW+1)'(1);

    always_comb begin
        n_val = r_val;
        case (i_cmd.op)
            OP_INS: begin
                if (MY_IDX == c_pos) begin
                    n_val = i_cmd.key;
                end else if (MY_IDX > c_pos) begin
                    n_val = i_prev;
                end
            end
            OP_SWP: begin
                if (MY_IDX == c_pos) begin
                    n_val = i_next;
                end else if (MY_IDX == c_pos_nx) begin
                    n_val = i_prev;
                end
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (i_cmd.op == OP_CMP) begin
            r_eq <= (r_val == i_cmd.key);
            r_gt <= (r_val > i_cmd.key);
        end
    end

    assign o_val = r_val;
    assign o_eq  = r_eq;
    assign o_gt  = r_gt;

endmodule

`default_nettype wire

// ----- rtl/core/stfsi_ctrl.sv -----
`default_nettype none

module stfsi_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [stfsi_pkg::KEY_W-1:0]  i_key,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [stfsi_pkg::OUTCOME_W-1:0]          o_outcome,
    output logic [stfsi_pkg::POSITION_W-1:0]         o_position,
    output logic [stfsi_pkg::COUNT_W-1:0]            o_count,
    input  wire logic [DEPTH-1:0]                    i_eq,
    input  wire logic [DEPTH-1:0]                    i_gt,
    output stfsi_pkg::t_cell_cmd                     o_cmd,
    output logic [AW-1:0]                            o_pos
);
    import stfsi_pkg::*;

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    t_state                  r_state;
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_hi;
    logic [CW-1:0]           r_used;
    logic                    r_ovalid;
    t_outcome                r_outcome;
    logic [AW-1:0]           r_pos;
    logic [CW-1:0]           r_cnt;

    logic [CW:0]             c_sum;
    logic [AW-1:0]           c_mid;
    logic [CW-1:0]           c_mid_w;
    logic                    c_miss;
    logic                    c_hit;
    logic                    c_done;
    logic                    c_out_free;
    logic                    c_accept;
    logic                    c_finish;
    logic                    c_swap;
    logic                    c_full;
    logic [AW+POSITION_W-1:0] c_pos_ext;
    logic [CW+COUNT_W-1:0]   c_cnt_ext;

    assign c_accept   = (r_state == ST_IDLE) && i_valid;
    assign c_out_free = !r_ovalid || !i_stall;
    assign c_sum      = {1'b0, r_lo} + {1'b0, r_hi} - (CW+1)'(1);
    assign c_mid      = c_sum[AW:1];
    assign c_mid_w    = CW'(c_mid);
    assign c_miss     = (r_lo >= r_hi);
    assign c_hit      = !c_miss && i_eq[c_mid];
    assign c_done     = c_miss || c_hit;
    assign c_finish   = (r_state == ST_SEARCH) && c_done && c_out_free;
    assign c_swap     = (c_mid_w + CW'(1)) < r_used;
    assign c_full     = (r_used == FULL_CNT);

    always_comb begin
        o_cmd.op  = OP_HOLD;
        o_cmd.key = r_key;
        o_pos     = c_mid;
        if (c_accept) begin
            o_cmd.op  = OP_CMP;
            o_cmd.key = i_key;
        end else if (r_state == ST_SEARCH && c_done && c_out_free) begin
            if (c_hit) begin
                if (c_swap) begin
                    o_cmd.op = OP_SWP;
                end
            end else if (!c_full) begin
                o_cmd.op = OP_INS;
                o_pos    = r_lo[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (c_finish) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_key   <= i_key;
                        r_lo    <= '0;
                        r_hi    <= r_used;
                        r_state <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (!c_done) begin
                        if (i_gt[c_mid]) begin
                            r_hi <= c_mid_w;
                        end else begin
                            r_lo <= c_mid_w + CW'(1);
                        end
                    end else if (c_out_free) begin
                        r_state  <= ST_IDLE;
                        if (c_hit) begin
                            r_pos     <= c_mid;
                            r_outcome <= c_swap ? OC_SWAPPED : OC_LAST;
                            r_cnt     <= r_used;
                        end else if (c_full) begin
                            r_pos     <= '0;
                            r_outcome <= OC_FULL;
                            r_cnt     <= r_used;
                        end else begin
                            r_pos     <= r_lo[AW-1:0];
                            r_outcome <= OC_INSERTED;
                            r_used    <= r_used + CW'(1);
                            r_cnt     <= r_used + CW'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign c_pos_ext  = {{POSITION_W{1'b0}}, r_pos};
    assign c_cnt_ext  = {{COUNT_W{1'b0}}, r_cnt};

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_ovalid;
    assign o_outcome  = r_outcome;
    assign o_position = c_pos_ext[POSITION_W-1:0];
    assign o_count    = c_cnt_ext[COUNT_W-1:0];

endmodule

`default_nettype wire
